// ===== sv/spm_pkg.sv =====
package spm_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int MATCH_LIMIT = 1024;

	localparam int IDX_W = $clog2(MAX_PATTERN);
	localparam int LEN_W = 5;
	localparam int CNT_W = 11;
	localparam int POS_W = 32;
	localparam int CFG_W = 64;
	localparam int REG_IDX_W = 8;

	typedef logic [7:0] byte_t;
	typedef byte_t [MAX_PATTERN-1:0] window_t;

	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW = 8'd0;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH = 8'd1;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 8'd2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_MATCHES = 8'd3;

	localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;
	localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(MATCH_LIMIT);

endpackage

// ===== sv/spm_compare.sv =====
module spm_compare (
	input  spm_pkg::window_t               window,
	input  spm_pkg::window_t               pattern,
	input  logic [spm_pkg::IDX_W-1:0]      len_m1,
	output logic                           hit
);

	logic [spm_pkg::IDX_W-1:0] idx;

	// Window entry j must equal pattern byte len-1-j for every j below the length.
	always_comb begin
		hit = 1'b1;
		for (int j = 0; j < spm_pkg::MAX_PATTERN; j++) begin
			idx = len_m1 - spm_pkg::IDX_W'(j);
			if (spm_pkg::IDX_W'(j) <= len_m1 && window[j] != pattern[idx]) begin
				hit = 1'b0;
			end
		end
	end

endmodule

// ===== sv/stream_pattern_match.sv =====
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid/s_tready    s_tdata[7:0] data_byte
// m_*       out        m_tvalid/m_tready    m_tdata match_location, match_number; m_tlast
// cfg_*     in         cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// One byte is accepted per cycle unless the input stalls. A byte is registered, then
// compared against the whole pattern window; its result is registered in the result
// register, which offers it. Input stalls only while the result register holds an untaken result.
// Reset restores the power-up registers and clears the window, position and count.
// Once the match limit is reached, bytes are still accepted but ignored.
module stream_pattern_match (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // data_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [47:0]                       m_tdata,   // match_location, match_number, zero fill
	output logic                              m_tlast,   // limit_reached
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [spm_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [spm_pkg::CFG_W-1:0]         cfg_data
);

	logic [spm_pkg::CFG_W-1:0]     pat_low_q;
	logic [spm_pkg::CFG_W-1:0]     pat_high_q;
	logic [spm_pkg::LEN_W-1:0]     pat_len_q;
	logic [spm_pkg::CNT_W-1:0]     max_matches_q;

	spm_pkg::window_t              recent_q;
	logic [spm_pkg::POS_W-1:0]     pos_q;
	logic [spm_pkg::LEN_W-1:0]     cooldown_q;
	logic [spm_pkg::CNT_W-1:0]     count_q;
	logic                          stopped_q;

	logic                          valid_s1;
	spm_pkg::byte_t                byte_s1;

	logic                          out_valid_q;
	logic [spm_pkg::POS_W-1:0]     loc_q;
	logic [spm_pkg::CNT_W-1:0]     num_q;
	logic                          lim_q;

	logic                          advance;
	logic                          process;
	spm_pkg::window_t              window;
	spm_pkg::window_t              pattern;
	logic [spm_pkg::LEN_W-1:0]     len_eff;
	logic [spm_pkg::IDX_W-1:0]     len_m1;
	logic [spm_pkg::CNT_W-1:0]     limit_eff;
	logic [spm_pkg::CNT_W-1:0]     count_next;
	logic                          hit;
	logic                          found;

	assign cfg_ready = 1'b1;
	assign advance = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign process = valid_s1 && advance && !stopped_q;

	always_comb begin
		window = {recent_q[spm_pkg::MAX_PATTERN-2:0], byte_s1};
		for (int k = 0; k < spm_pkg::MAX_PATTERN; k++) begin
			if (k < 8) begin
				pattern[k] = pat_low_q[8*(k%8) +: 8];
			end else begin
				pattern[k] = pat_high_q[8*(k%8) +: 8];
			end
		end
		if (pat_len_q == '0) begin
			len_eff = spm_pkg::LEN_W'(1);
		end else if (pat_len_q > spm_pkg::LEN_W'(spm_pkg::MAX_PATTERN)) begin
			len_eff = spm_pkg::LEN_W'(spm_pkg::MAX_PATTERN);
		end else begin
			len_eff = pat_len_q;
		end
		if (max_matches_q == '0) begin
			limit_eff = spm_pkg::CNT_W'(1);
		end else if (max_matches_q > spm_pkg::LIMIT_RESET) begin
			limit_eff = spm_pkg::LIMIT_RESET;
		end else begin
			limit_eff = max_matches_q;
		end
	end

	assign len_m1 = spm_pkg::IDX_W'(len_eff - spm_pkg::LEN_W'(1));
	assign count_next = count_q + spm_pkg::CNT_W'(1);

	spm_compare u_compare (
		.window  (window),
		.pattern (pattern),
		.len_m1  (len_m1),
		.hit     (hit)
	);

	assign found = process && cooldown_q == '0
		&& pos_q >= spm_pkg::POS_W'(len_m1) && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q <= '0;
			pat_high_q <= '0;
			pat_len_q <= spm_pkg::LEN_RESET;
			max_matches_q <= spm_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				spm_pkg::REG_PATTERN_LOW: pat_low_q <= cfg_data;
				spm_pkg::REG_PATTERN_HIGH: pat_high_q <= cfg_data;
				spm_pkg::REG_PATTERN_LENGTH: pat_len_q <= cfg_data[spm_pkg::LEN_W-1:0];
				spm_pkg::REG_MAX_MATCHES: max_matches_q <= cfg_data[spm_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			pos_q <= '0;
			cooldown_q <= '0;
			count_q <= '0;
			stopped_q <= 1'b0;
		end else if (process) begin
			recent_q <= window;
			if (pos_q != '1) begin
				pos_q <= pos_q + spm_pkg::POS_W'(1);
			end
			if (cooldown_q != '0) begin
				cooldown_q <= cooldown_q - spm_pkg::LEN_W'(1);
			end else if (found) begin
				cooldown_q <= spm_pkg::LEN_W'(len_m1);
				count_q <= count_next;
				stopped_q <= count_next >= limit_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= found;
		end
	end

	always_ff @(posedge clk) begin
		if (found) begin
			loc_q <= pos_q - spm_pkg::POS_W'(len_m1);
			num_q <= count_next;
			lim_q <= count_next >= limit_eff;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {5'd0, num_q, loc_q};
	assign m_tlast = lim_q;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

	localparam logic [spm_pkg::REG_IDX_W-1:0] REG_NONE = 8'hFF;
	localparam int DRAIN_CYCLES = 6;
	localparam int FILL_W = 48 - spm_pkg::POS_W - spm_pkg::CNT_W;

	typedef struct packed {
		logic [spm_pkg::POS_W-1:0] location;
		logic [spm_pkg::CNT_W-1:0] number;
		logic                      last;
	} match_t;

	class match_tracker;
		spm_pkg::window_t          pattern;
		logic [spm_pkg::LEN_W-1:0] length_reg;
		logic [spm_pkg::CNT_W-1:0] limit_reg;
		spm_pkg::window_t          recent;
		logic [spm_pkg::POS_W-1:0] position;
		logic [spm_pkg::LEN_W-1:0] cooldown;
		logic [spm_pkg::CNT_W-1:0] found;
		bit                        stopped;
		match_t                    expected[$];
		int                        errors;

		function new();
			pattern = '0;
			length_reg = spm_pkg::LEN_RESET;
			limit_reg = spm_pkg::LIMIT_RESET;
			recent = '0;
			position = '0;
			cooldown = '0;
			found = '0;
			stopped = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [spm_pkg::REG_IDX_W-1:0] idx,
			logic [spm_pkg::CFG_W-1:0] data);
			case (idx)
				spm_pkg::REG_PATTERN_LOW: pattern[7:0] = data;
				spm_pkg::REG_PATTERN_HIGH: pattern[15:8] = data;
				spm_pkg::REG_PATTERN_LENGTH: length_reg = data[spm_pkg::LEN_W-1:0];
				spm_pkg::REG_MAX_MATCHES: limit_reg = data[spm_pkg::CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_byte(spm_pkg::byte_t b);
			int unsigned               len;
			int unsigned               lim;
			logic [spm_pkg::POS_W-1:0] p;
			bit                        hit;
			match_t                    m;
			if (stopped)
				return;
			recent = {recent[spm_pkg::MAX_PATTERN-2:0], b};
			len = (length_reg == 0) ? 1 : ((length_reg > spm_pkg::MAX_PATTERN) ?
				spm_pkg::MAX_PATTERN : length_reg);
			p = position;
			if (position != '1)
				position++;
			if (cooldown != 0) begin
				cooldown--;
				return;
			end
			if (p < len - 1)
				return;
			hit = 1'b1;
			for (int i = 0; i < len; i++)
				if (recent[len - 1 - i] != pattern[i])
					hit = 1'b0;
			if (!hit)
				return;
			cooldown = spm_pkg::LEN_W'(len - 1);
			found++;
			lim = (limit_reg == 0) ? 1 : ((limit_reg > spm_pkg::MATCH_LIMIT) ?
				spm_pkg::MATCH_LIMIT : limit_reg);
			if (found >= lim)
				stopped = 1'b1;
			m.location = p - spm_pkg::POS_W'(len - 1);
			m.number = found;
			m.last = stopped;
			expected.push_back(m);
		endfunction

		function void check_match(logic [47:0] tdata, logic tlast);
			match_t want;
			if (expected.size() == 0) begin
				$error("unexpected match at location %0d", tdata[spm_pkg::POS_W-1:0]);
				errors++;
				return;
			end
			want = expected.pop_front();
			if (tdata[spm_pkg::POS_W-1:0] !== want.location) begin
				$error("match_location: expected %0d, actual %0d", want.location,
					tdata[spm_pkg::POS_W-1:0]);
				errors++;
			end
			if (tdata[spm_pkg::POS_W +: spm_pkg::CNT_W] !== want.number) begin
				$error("match_number: expected %0d, actual %0d", want.number,
					tdata[spm_pkg::POS_W +: spm_pkg::CNT_W]);
				errors++;
			end
			if (tlast !== want.last) begin
				$error("limit_reached: expected %0d, actual %0d", want.last, tlast);
				errors++;
			end
			if (tdata[47 -: FILL_W] !== '0) begin
				$error("zero fill: expected 0, actual %0h", tdata[47 -: FILL_W]);
				errors++;
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic [7:0]                    s_tdata = '0;
	logic                          m_tready = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic [spm_pkg::REG_IDX_W-1:0] cfg_index = '0;
	logic [spm_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                          s_tready;
	logic                          m_tvalid;
	logic [47:0]                   m_tdata;
	logic                          m_tlast;
	logic                          cfg_ready;

	match_tracker     tracker = new();
	bit               quiet = 1'b0;
	spm_pkg::window_t search_pattern = '0;
	int               search_len = 1;
	spm_pkg::byte_t   alpha[2];
	bit               use_alpha = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	stream_pattern_match dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_match(m_tdata, m_tlast);
	end

	initial begin
		int gap;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				gap = $urandom_range(1, 7);
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [spm_pkg::REG_IDX_W-1:0] idx,
		input logic [spm_pkg::CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
	endtask

	task automatic push_byte(input spm_pkg::byte_t b);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 7);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		tracker.take_byte(b);
	endtask

	task automatic wait_idle();
		int n;
		s_tvalid <= 1'b0;
		n = 0;
		while (tracker.pending() != 0 && n < 2000) begin
			@(posedge clk);
			n++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(spm_pkg::byte_t'(s[i]));
	endtask

	function automatic spm_pkg::byte_t filler_byte();
		if (use_alpha && $urandom_range(0, 3) != 0)
			return alpha[$urandom_range(0, 1)];
		return spm_pkg::byte_t'($urandom);
	endfunction

	// Mostly whole copies of the pattern, some cut short, some filler in between.
	task automatic push_search_stream(input int target);
		int sent;
		int cut;
		int k;
		sent = 0;
		while (sent < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: cut = search_len;
				5, 6: cut = (search_len > 1) ? $urandom_range(1, search_len - 1) : 1;
				default: cut = 0;
			endcase
			if (cut == 0) begin
				k = $urandom_range(1, 4);
				repeat (k) begin
					push_byte(filler_byte());
					sent++;
				end
			end else begin
				for (int i = 0; i < cut; i++) begin
					push_byte(search_pattern[i]);
					sent++;
				end
			end
		end
	endtask

	initial begin
		int                        len_value;
		logic [spm_pkg::CFG_W-1:0] word;
		spm_pkg::window_t          pat;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Power-up registers: a single zero byte is the pattern.
		push_byte(8'h00);
		wait_idle();
		// Too few bytes seen for a four-byte pattern until position three.
		write_reg(spm_pkg::REG_PATTERN_LENGTH, 64'd4);
		cfg_valid <= 1'b0;
		repeat (3) push_byte(8'h00);
		wait_idle();
		// A mismatch must recheck the current byte as a possible start.
		write_reg(spm_pkg::REG_PATTERN_LOW, 64'h64616d);
		write_reg(spm_pkg::REG_PATTERN_LENGTH, 64'd3);
		cfg_valid <= 1'b0;
		push_text("mmadmad");
		wait_idle();
		write_reg(spm_pkg::REG_PATTERN_LOW, 64'h6161);
		write_reg(spm_pkg::REG_PATTERN_LENGTH, 64'd2);
		cfg_valid <= 1'b0;
		push_text("aaa");
		wait_idle();
		write_reg(spm_pkg::REG_PATTERN_LOW, 64'hff);
		write_reg(spm_pkg::REG_PATTERN_LENGTH, 64'd0);
		cfg_valid <= 1'b0;
		push_byte(8'hff);
		wait_idle();
		// Oversized length acts as the full window; its cooldown runs into the next phase.
		write_reg(spm_pkg::REG_PATTERN_LOW, '1);
		write_reg(spm_pkg::REG_PATTERN_HIGH, 64'd0);
		write_reg(spm_pkg::REG_PATTERN_LENGTH, 64'd17);
		cfg_valid <= 1'b0;
		repeat (8) push_byte(8'hff);
		repeat (8) push_byte(8'h00);

		for (int ph = 0; ph < 12; ph++) begin
			wait_idle();
			quiet = (ph >= 10);
			use_alpha = $urandom_range(0, 1);
			alpha[0] = spm_pkg::byte_t'($urandom);
			alpha[1] = spm_pkg::byte_t'($urandom);
			for (int i = 0; i < spm_pkg::MAX_PATTERN; i++)
				pat[i] = use_alpha ? alpha[$urandom_range(0, 1)] :
					spm_pkg::byte_t'($urandom);
			case ($urandom_range(0, 7))
				0: len_value = 0;
				1: len_value = 1;
				2: len_value = spm_pkg::MAX_PATTERN;
				3: len_value = $urandom_range(spm_pkg::MAX_PATTERN + 1, 31);
				default: len_value = $urandom_range(2, 8);
			endcase
			search_pattern = pat;
			search_len = (len_value == 0) ? 1 :
				((len_value > spm_pkg::MAX_PATTERN) ? spm_pkg::MAX_PATTERN : len_value);
			write_reg(spm_pkg::REG_PATTERN_LOW, pat[7:0]);
			write_reg(spm_pkg::REG_PATTERN_HIGH, pat[15:8]);
			word = {$urandom, $urandom};
			word[spm_pkg::LEN_W-1:0] = len_value[spm_pkg::LEN_W-1:0];
			write_reg(spm_pkg::REG_PATTERN_LENGTH, word);
			word = {$urandom, $urandom};
			case ($urandom_range(0, 2))
				0: word[spm_pkg::CNT_W-1:0] = spm_pkg::CNT_W'(spm_pkg::MATCH_LIMIT);
				1: word[spm_pkg::CNT_W-1:0] = '1;
				default: word[spm_pkg::CNT_W-1:0] = spm_pkg::CNT_W'(
					$urandom_range(spm_pkg::MATCH_LIMIT, (1 << spm_pkg::CNT_W) - 1));
			endcase
			write_reg(spm_pkg::REG_MAX_MATCHES, word);
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_NONE :
					spm_pkg::REG_IDX_W'($urandom_range(4, 254)), {$urandom, $urandom});
			cfg_valid <= 1'b0;
			push_search_stream($urandom_range(32, 48));
		end

		// A zero limit below the current count stops at the next match.
		wait_idle();
		word = {$urandom, $urandom};
		word[spm_pkg::CNT_W-1:0] = '0;
		write_reg(spm_pkg::REG_MAX_MATCHES, word);
		cfg_valid <= 1'b0;
		push_search_stream(60);
		wait_idle();

		if (tracker.pending() != 0) begin
			$error("%0d expected matches never arrived", tracker.pending());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
